FILE: rtl/hdf_pkg.sv
// shared types and constants of the heat diffusion grid step block
package hdf_pkg;

	localparam int VAL_W     = 32;
	localparam int FRAC_BITS = 16;
	localparam int EXT_W     = 5;
	localparam int COEF_W    = 16;
	localparam int ROW_W     = 4;
	localparam int COL_W     = 4;
	localparam int OP_W      = 2;
	localparam int KIND_W    = 2;
	localparam int IDX_W     = 2;
	localparam int CFG_W     = 16;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;

	localparam int LAP_W  = 35;
	localparam int PROD_W = 52;
	localparam int TOT_W  = 54;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STEP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	localparam logic [IDX_W-1:0] REG_ROWS     = 2'd0;
	localparam logic [IDX_W-1:0] REG_COLS     = 2'd1;
	localparam logic [IDX_W-1:0] REG_ROW_COEF = 2'd2;
	localparam logic [IDX_W-1:0] REG_COL_COEF = 2'd3;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [TOT_W-1:0] ROUND_HALF = 54'sh8000;

	typedef struct packed {
		logic                    fixed;
		logic signed [VAL_W-1:0] value;
	} bank_word_t;

endpackage

FILE: rtl/heat_diffusion_ftcs_grid_step.sv
// top level of the heat diffusion grid step block
//
// Holds two ping-pong banks of signed Q16.16 cell values, each word carrying
// the cell's fixed flag, in two RAMs of MAX_ROWS*MAX_COLS entries. After reset
// a clearing pass over all MAX_ROWS*MAX_COLS addresses zeroes both banks; no
// transaction is accepted during it, register writes are. A step item sweeps
// every storage cell: each cell of the active area is read in its up, mid and
// right phases (five neighbor reads through the two read ports of the current
// bank) and each cell outside it in its up phase alone; the multiply and round
// pipeline then drains before the result is given. The result register frees
// the input side as soon as the result is taken.
module heat_diffusion_ftcs_grid_step
	import hdf_pkg::*;
#(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // row, col, cell_value, held_fixed
	input  logic [OP_W-1:0]      s_tuser,   // opcode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // read_value, saturated
	output logic [KIND_W-1:0]    m_tuser,   // result_kind
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int NRW   = $clog2(MAX_ROWS + 1);
	localparam int NCW   = $clog2(MAX_COLS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_STEP = 2'd2;

	localparam logic [1:0] PH_UP    = 2'd0;
	localparam logic [1:0] PH_MID   = 2'd1;
	localparam logic [1:0] PH_RIGHT = 2'd2;

	function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] r, input logic [AW-1:0] c);
		return AW'(int'(r) * MAX_COLS + int'(c));
	endfunction

	// configuration
	logic [EXT_W-1:0]  rows_q;
	logic [EXT_W-1:0]  cols_q;
	logic [COEF_W-1:0] row_coef_q;
	logic [COEF_W-1:0] col_coef_q;

	// control
	logic [1:0]    state_q;
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;
	logic          cur_bank_q;
	logic          rd_inside_q;
	logic [1:0]    ph_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic          sweep_done_q;
	logic          iss_vld_q;
	logic [1:0]    iss_ph_q;
	logic          iss_act_q;
	logic [AW-1:0] iss_addr_q;
	logic          sat_q;

	// output register
	logic                    m_tvalid_q;
	logic [KIND_W-1:0]       m_kind_q;
	logic signed [VAL_W-1:0] m_value_q;
	logic                    m_sat_q;

	// gathered neighbors
	logic signed [VAL_W-1:0] u_q, up_q, dn_q, lf_q;
	logic                    fix_q;

	// pipeline
	logic                     vld_s2, vld_s3, vld_s4;
	logic                     keep_s2, keep_s3, keep_s4;
	logic                     fix_s2, fix_s3, fix_s4;
	logic signed [VAL_W-1:0]  u_s2, u_s3, u_s4;
	logic [AW-1:0]            addr_s2, addr_s3, addr_s4;
	logic signed [LAP_W-1:0]  lap_r_s2, lap_c_s2;
	logic signed [PROD_W-1:0] prod_r_s3, prod_c_s3;
	logic signed [TOT_W-1:0]  total_s4;

	// input item fields
	logic [OP_W-1:0]         in_op;
	logic [ROW_W-1:0]        in_row;
	logic [COL_W-1:0]        in_col;
	logic signed [VAL_W-1:0] in_value;
	logic                    in_fix;
	logic                    in_inside;
	logic [AW-1:0]           in_addr;
	logic                    accept;
	logic                    item_write;

	logic [NRW-1:0] nr;
	logic [NCW-1:0] nc;
	logic [RW-1:0]  nr_last, row_up, row_dn;
	logic [CW-1:0]  nc_last, col_lf, col_rt;
	logic           active;
	logic           last_cell;
	logic           cell_end;
	logic           drained;

	logic [AW-1:0] raddr0, raddr1, waddr;
	logic          we_a, we_b;
	bank_word_t    wdata, rd_a0, rd_a1, rd_b0, rd_b1, d0, d1;

	logic signed [LAP_W-1:0] lap_r, lap_c;
	logic                    ovf;
	logic signed [VAL_W-1:0] res;

	assign in_op     = s_tuser;
	assign in_row    = s_tdata[ROW_W-1:0];
	assign in_col    = s_tdata[ROW_W+COL_W-1:ROW_W];
	assign in_value  = s_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];
	assign in_fix    = s_tdata[ROW_W+COL_W+VAL_W];
	assign in_inside = (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);
	assign in_addr   = cell_addr(AW'(in_row), AW'(in_col));

	assign s_tready   = (state_q == ST_IDLE) && !clr_q && (!m_tvalid_q || m_tready);
	assign accept     = s_tvalid && s_tready;
	assign item_write = accept && (in_op == OP_WRITE) && in_inside;
	assign cfg_ready  = 1'b1;

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_kind_q;
	assign m_tdata  = {{(M_TDATA_W-VAL_W-1){1'b0}}, m_sat_q, m_value_q};

	// active extents
	always_comb begin
		if (rows_q < EXT_W'(2)) begin
			nr = NRW'(2);
		end else if (int'(rows_q) > MAX_ROWS) begin
			nr = NRW'(MAX_ROWS);
		end else begin
			nr = NRW'(rows_q);
		end
		if (cols_q < EXT_W'(2)) begin
			nc = NCW'(2);
		end else if (int'(cols_q) > MAX_COLS) begin
			nc = NCW'(MAX_COLS);
		end else begin
			nc = NCW'(cols_q);
		end
	end

	// periodic neighbors
	assign nr_last   = RW'(nr - NRW'(1));
	assign nc_last   = CW'(nc - NCW'(1));
	assign row_up    = (r_q == '0) ? nr_last : r_q - 1'b1;
	assign row_dn    = (r_q == nr_last) ? '0 : r_q + 1'b1;
	assign col_lf    = (c_q == '0) ? nc_last : c_q - 1'b1;
	assign col_rt    = (c_q == nc_last) ? '0 : c_q + 1'b1;
	assign active    = (NRW'(r_q) < nr) && (NCW'(c_q) < nc);
	assign last_cell = (r_q == RW'(MAX_ROWS - 1)) && (c_q == CW'(MAX_COLS - 1));
	assign cell_end  = (ph_q == PH_RIGHT) || ((ph_q == PH_UP) && !active);
	assign drained   = sweep_done_q && !iss_vld_q && !vld_s2 && !vld_s3 && !vld_s4;

	// read addresses
	always_comb begin
		raddr0 = in_addr;
		raddr1 = in_addr;
		if (state_q == ST_STEP) begin
			case (ph_q)
				PH_MID: begin
					raddr0 = cell_addr(AW'(row_dn), AW'(c_q));
					raddr1 = cell_addr(AW'(r_q), AW'(col_lf));
				end
				PH_RIGHT: begin
					raddr0 = cell_addr(AW'(r_q), AW'(col_rt));
					raddr1 = cell_addr(AW'(r_q), AW'(c_q));
				end
				default: begin
					raddr0 = cell_addr(AW'(r_q), AW'(c_q));
					raddr1 = cell_addr(AW'(row_up), AW'(c_q));
				end
			endcase
		end
	end

	assign d0 = cur_bank_q ? rd_b0 : rd_a0;
	assign d1 = cur_bank_q ? rd_b1 : rd_a1;

	// laplacian terms, right neighbor arrives in the last gather cycle
	assign lap_r = LAP_W'(up_q) + LAP_W'(dn_q) - (LAP_W'(u_q) <<< 1);
	assign lap_c = LAP_W'(lf_q) + LAP_W'(d0.value) - (LAP_W'(u_q) <<< 1);

	// round result and saturate
	assign ovf = !((&total_s4[TOT_W-1:FRAC_BITS+VAL_W-1]) ||
		!(|total_s4[TOT_W-1:FRAC_BITS+VAL_W-1]));
	assign res = ovf ? (total_s4[TOT_W-1] ? VAL_MIN : VAL_MAX)
		: total_s4[FRAC_BITS+VAL_W-1:FRAC_BITS];

	// write port
	always_comb begin
		we_a  = 1'b0;
		we_b  = 1'b0;
		waddr = in_addr;
		wdata = '{fixed: in_fix, value: in_value};
		if (clr_q) begin
			we_a  = 1'b1;
			we_b  = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else if (vld_s4) begin
			we_a  = cur_bank_q;
			we_b  = !cur_bank_q;
			waddr = addr_s4;
			wdata = '{fixed: fix_s4, value: keep_s4 ? u_s4 : res};
		end else if (item_write) begin
			we_a = 1'b1;
			we_b = 1'b1;
		end
	end

	hdf_ram #(
		.WIDTH($bits(bank_word_t)),
		.DEPTH(CELLS)
	) u_bank_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.raddr0(raddr0),
		.rdata0(rd_a0),
		.raddr1(raddr1),
		.rdata1(rd_a1)
	);

	hdf_ram #(
		.WIDTH($bits(bank_word_t)),
		.DEPTH(CELLS)
	) u_bank_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.raddr0(raddr0),
		.rdata0(rd_b0),
		.raddr1(raddr1),
		.rdata1(rd_b1)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= EXT_W'(16);
			cols_q     <= EXT_W'(16);
			row_coef_q <= '0;
			col_coef_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROWS:     rows_q     <= cfg_data[EXT_W-1:0];
				REG_COLS:     cols_q     <= cfg_data[EXT_W-1:0];
				REG_ROW_COEF: row_coef_q <= cfg_data[COEF_W-1:0];
				REG_COL_COEF: col_coef_q <= cfg_data[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// control and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			clr_q        <= 1'b1;
			clr_addr_q   <= '0;
			cur_bank_q   <= 1'b0;
			rd_inside_q  <= 1'b0;
			ph_q         <= PH_UP;
			r_q          <= '0;
			c_q          <= '0;
			sweep_done_q <= 1'b1;
			iss_vld_q    <= 1'b0;
			iss_ph_q     <= PH_UP;
			iss_act_q    <= 1'b0;
			iss_addr_q   <= '0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			vld_s4       <= 1'b0;
			sat_q        <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (clr_q) begin
				if (clr_addr_q == AW'(CELLS - 1)) begin
					clr_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end

			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			vld_s2 <= iss_vld_q && ((iss_ph_q == PH_RIGHT) || ((iss_ph_q == PH_UP) && !iss_act_q));
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			if (vld_s4 && !keep_s4 && ovf) begin
				sat_q <= 1'b1;
			end

			iss_vld_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (in_op)
							OP_WRITE: begin
								m_tvalid_q <= 1'b1;
							end
							OP_STEP: begin
								state_q      <= ST_STEP;
								ph_q         <= PH_UP;
								r_q          <= '0;
								c_q          <= '0;
								sweep_done_q <= 1'b0;
								sat_q        <= 1'b0;
							end
							OP_READ: begin
								state_q     <= ST_READ;
								rd_inside_q <= in_inside;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					m_tvalid_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				ST_STEP: begin
					if (!sweep_done_q) begin
						iss_vld_q  <= 1'b1;
						iss_ph_q   <= ph_q;
						iss_act_q  <= active;
						iss_addr_q <= cell_addr(AW'(r_q), AW'(c_q));
						if (cell_end) begin
							ph_q <= PH_UP;
							if (last_cell) begin
								sweep_done_q <= 1'b1;
							end else if (c_q == CW'(MAX_COLS - 1)) begin
								c_q <= '0;
								r_q <= r_q + 1'b1;
							end else begin
								c_q <= c_q + 1'b1;
							end
						end else begin
							ph_q <= ph_q + 1'b1;
						end
					end else if (drained) begin
						m_tvalid_q <= 1'b1;
						cur_bank_q <= !cur_bank_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && in_op == OP_WRITE) begin
			m_kind_q  <= KIND_WRITE;
			m_value_q <= '0;
			m_sat_q   <= 1'b0;
		end else if (state_q == ST_READ) begin
			m_kind_q  <= KIND_READ;
			m_value_q <= rd_inside_q ? d0.value : '0;
			m_sat_q   <= 1'b0;
		end else if (state_q == ST_STEP && sweep_done_q && drained) begin
			m_kind_q  <= KIND_STEP;
			m_value_q <= '0;
			m_sat_q   <= sat_q;
		end
	end

	// neighbor gather and arithmetic pipeline
	always_ff @(posedge clk) begin
		if (iss_vld_q) begin
			case (iss_ph_q)
				PH_UP: begin
					u_q     <= d0.value;
					fix_q   <= d0.fixed;
					up_q    <= d1.value;
					u_s2    <= d0.value;
					fix_s2  <= d0.fixed;
					keep_s2 <= 1'b1;
					addr_s2 <= iss_addr_q;
				end
				PH_MID: begin
					dn_q <= d0.value;
					lf_q <= d1.value;
				end
				PH_RIGHT: begin
					u_s2     <= u_q;
					fix_s2   <= fix_q;
					keep_s2  <= fix_q;
					addr_s2  <= iss_addr_q;
					lap_r_s2 <= lap_r;
					lap_c_s2 <= lap_c;
				end
				default: begin
				end
			endcase
		end

		prod_r_s3 <= PROD_W'($signed({1'b0, row_coef_q})) * PROD_W'(lap_r_s2);
		prod_c_s3 <= PROD_W'($signed({1'b0, col_coef_q})) * PROD_W'(lap_c_s2);
		u_s3      <= u_s2;
		fix_s3    <= fix_s2;
		keep_s3   <= keep_s2;
		addr_s3   <= addr_s2;

		total_s4 <= (TOT_W'(u_s3) <<< FRAC_BITS) + TOT_W'(prod_r_s3) + TOT_W'(prod_c_s3)
			+ ROUND_HALF;
		u_s4    <= u_s3;
		fix_s4  <= fix_s3;
		keep_s4 <= keep_s3;
		addr_s4 <= addr_s3;
	end

endmodule

FILE: rtl/hdf_ram.sv
// generic ram with one write port and two registered read ports
module hdf_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	output logic [WIDTH-1:0]         rdata0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the heat diffusion grid step block
module testbench;
	import hdf_pkg::*;

	localparam int CELLS = 256;
	localparam int GRID_ROWS = 16;
	localparam int GRID_COLS = 16;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [VAL_W-1:0]  value;
		logic              sat;
	} grid_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // row, col, cell_value, held_fixed
	logic [OP_W-1:0]      s_tuser;   // opcode
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // read_value, saturated
	logic [KIND_W-1:0]    m_tuser;   // result_kind
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [IDX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// grid model and its settings
	logic signed [VAL_W-1:0] grid_val [CELLS];
	bit                      fixed_cell [CELLS];
	int                      rows_cfg;
	int                      cols_cfg;
	int                      row_coef;
	int                      col_coef;
	grid_result_t            pending_results [$];

	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	int hold_cycles = 0;

	int mismatches = 0;
	int n_checked = 0;
	int n_writes = 0;
	int n_reads = 0;
	int n_steps = 0;
	int n_clipped = 0;
	int n_ignored = 0;
	int n_settings = 0;

	always #2 clk = ~clk;

	heat_diffusion_ftcs_grid_step dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// one explicit time step over the active area, periodic wrap, round half up
	function automatic bit diffuse_grid();
		logic signed [VAL_W-1:0] prev [CELLS];
		int nr, nc, r, c, up, dn, lf, rt, idx;
		longint u, lap_r, lap_c, total;
		bit clipped;
		clipped = 1'b0;
		prev = grid_val;
		nr = (rows_cfg < 2) ? 2 : (rows_cfg > GRID_ROWS) ? GRID_ROWS : rows_cfg;
		nc = (cols_cfg < 2) ? 2 : (cols_cfg > GRID_COLS) ? GRID_COLS : cols_cfg;
		for (r = 0; r < nr; r++) begin
			up = (r == 0) ? nr - 1 : r - 1;
			dn = (r == nr - 1) ? 0 : r + 1;
			for (c = 0; c < nc; c++) begin
				lf = (c == 0) ? nc - 1 : c - 1;
				rt = (c == nc - 1) ? 0 : c + 1;
				idx = r * GRID_COLS + c;
				if (!fixed_cell[idx]) begin
					u = prev[idx];
					lap_r = longint'(prev[up * GRID_COLS + c])
						+ longint'(prev[dn * GRID_COLS + c]) - 2 * u;
					lap_c = longint'(prev[r * GRID_COLS + lf])
						+ longint'(prev[r * GRID_COLS + rt]) - 2 * u;
					total = u * 65536 + longint'(row_coef) * lap_r
						+ longint'(col_coef) * lap_c + 64'sh8000;
					total = total >>> FRAC_BITS;
					if (total > longint'(VAL_MAX)) begin
						total = longint'(VAL_MAX);
						clipped = 1'b1;
					end else if (total < longint'(VAL_MIN)) begin
						total = longint'(VAL_MIN);
						clipped = 1'b1;
					end
					grid_val[idx] = total[VAL_W-1:0];
				end
			end
		end
		return clipped;
	endfunction

	// queue one expected result behind the outstanding ones
	function automatic void expect_result(input grid_result_t outcome);
		pending_results.insert(pending_results.size(), outcome);
	endfunction

	function automatic void apply_grid_item(input logic [OP_W-1:0] op,
			input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
			input logic [VAL_W-1:0] val, input logic fix);
		int idx;
		grid_result_t outcome;
		idx = int'(row) * GRID_COLS + int'(col);
		outcome.value = '0;
		outcome.sat = 1'b0;
		case (op)
		OP_WRITE: begin
			grid_val[idx] = val;
			fixed_cell[idx] = fix;
			outcome.kind = KIND_WRITE;
			expect_result(outcome);
			n_writes++;
		end
		OP_STEP: begin
			outcome.kind = KIND_STEP;
			outcome.sat = diffuse_grid();
			expect_result(outcome);
			n_steps++;
			if (outcome.sat)
				n_clipped++;
		end
		OP_READ: begin
			outcome.kind = KIND_READ;
			outcome.value = grid_val[idx];
			expect_result(outcome);
			n_reads++;
		end
		default: n_ignored++;
		endcase
	endfunction

	task automatic send_item(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val, input logic fix);
		int gap;
		gap = tx_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(S_TDATA_W - 41){1'b0}}, fix, val, col, row};
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		apply_grid_item(op, row, col, val, fix);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		case (index)
		REG_ROWS:     rows_cfg = data[EXT_W-1:0];
		REG_COLS:     cols_cfg = data[EXT_W-1:0];
		REG_ROW_COEF: row_coef = data[COEF_W-1:0];
		REG_COL_COEF: col_coef = data[COEF_W-1:0];
		endcase
	endtask

	task automatic configure(input logic [CFG_W-1:0] rows_d, input logic [CFG_W-1:0] cols_d,
			input logic [CFG_W-1:0] rc, input logic [CFG_W-1:0] cc);
		wait_idle();
		write_reg(REG_ROWS, rows_d);
		write_reg(REG_COLS, cols_d);
		write_reg(REG_ROW_COEF, rc);
		write_reg(REG_COL_COEF, cc);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	function automatic logic [VAL_W-1:0] random_value();
		case ($urandom_range(0, 5))
		0:       return VAL_MAX;
		1:       return VAL_MIN;
		2:       return '0;
		3:       return $urandom;
		4:       return $urandom_range(0, 32'h001f_ffff) - 32'h0010_0000;
		default: return $urandom_range(0, 32'h1fff_ffff) - 32'h1000_0000;
		endcase
	endfunction

	task automatic random_item(input bit with_steps);
		int pick;
		logic [OP_W-1:0] op;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			op = OP_WRITE;
		else if (pick < 85 || !with_steps)
			op = OP_READ;
		else if (pick < 96)
			op = OP_STEP;
		else
			op = OP_UNUSED;
		send_item(op, ROW_W'($urandom_range(0, GRID_ROWS - 1)),
			COL_W'($urandom_range(0, GRID_COLS - 1)),
			random_value(), $urandom_range(0, 3) == 0);
	endtask

	task automatic test_reset_state();
		send_item(OP_READ, 0, 0, '0, 1'b0);
		send_item(OP_READ, 15, 15, '0, 1'b0);
		send_item(OP_STEP, 0, 0, '0, 1'b0);
		send_item(OP_UNUSED, 7, 9, 32'hdead_beef, 1'b1);
		send_item(OP_READ, 7, 9, '0, 1'b0);
	endtask

	task automatic test_write_read();
		send_item(OP_WRITE, 0, 0, VAL_MAX, 1'b0);
		send_item(OP_WRITE, 15, 15, VAL_MIN, 1'b1);
		send_item(OP_WRITE, 3, 12, 32'h5a5a_a5a5, 1'b1);
		// fixed flag cleared again by the second write
		send_item(OP_WRITE, 3, 12, 32'ha5a5_5a5a, 1'b0);
		send_item(OP_STEP, 0, 0, '0, 1'b0);
		send_item(OP_READ, 0, 0, '0, 1'b0);
		send_item(OP_READ, 15, 15, '0, 1'b0);
		send_item(OP_READ, 3, 12, '0, 1'b0);
	endtask

	task automatic test_clipping();
		// rows below range with junk upper bits, cols above range, full coefficients
		configure(16'hffe0, 16'h001f, 16'hffff, 16'hffff);
		send_item(OP_WRITE, 0, 0, VAL_MAX, 1'b0);
		send_item(OP_WRITE, 1, 0, VAL_MIN, 1'b0);
		send_item(OP_WRITE, 0, 1, VAL_MIN, 1'b0);
		send_item(OP_WRITE, 5, 5, 32'h0004_8000, 1'b0);
		send_item(OP_STEP, 0, 0, '0, 1'b0);
		send_item(OP_READ, 0, 0, '0, 1'b0);
		send_item(OP_READ, 1, 0, '0, 1'b0);
		send_item(OP_READ, 5, 5, '0, 1'b0);
		send_item(OP_STEP, 0, 0, '0, 1'b0);
		send_item(OP_READ, 0, 1, '0, 1'b0);
	endtask

	task automatic test_backpressure();
		configure(16, 16, 16'h1000, 16'h3000);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_cycles = HOLD_OFF_CYCLES;
		repeat (2) @(posedge clk);
		repeat (30) random_item(1'b0);
		// sender waits for every outstanding result
		wait_idle();
		repeat (10) random_item(1'b1);
	endtask

	task automatic test_random_phases();
		int p;
		for (p = 0; p < 8; p++) begin
			case (p)
			0: configure(16, 16, 16'h2000, 16'h2000);
			1: configure(2, 2, 16'hffff, 16'hffff);
			2: configure(1, 17, 16'h0000, 16'hffff);
			3: configure(16, 2, 16'hffff, 16'h0000);
			default: configure(CFG_W'($urandom_range(0, 31)), CFG_W'($urandom_range(0, 31)),
				CFG_W'($urandom_range(0, 16'hffff)), CFG_W'($urandom_range(0, 16'hffff)));
			endcase
			tx_idle = p[0];
			rx_idle = p[1];
			repeat (160) random_item(1'b1);
		end
	endtask

	initial begin : result_monitor
		int stall;
		grid_result_t got;
		grid_result_t want;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = rx_idle ? $urandom_range(0, 8) : 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(negedge clk);
			while (!m_tvalid && hold_cycles == 0) @(negedge clk);
			if (m_tvalid) begin
				got.kind = m_tuser;
				got.value = m_tdata[VAL_W-1:0];
				got.sat = m_tdata[VAL_W];
				@(posedge clk);
				if (pending_results.size() == 0) begin
					$error("result with nothing outstanding, result_kind %0d", got.kind);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					n_checked++;
					if (got.kind !== want.kind) begin
						$error("result_kind: expected %0d, got %0d", want.kind, got.kind);
						mismatches++;
					end
					if (got.value !== want.value) begin
						$error("read_value: expected %h, got %h", want.value, got.value);
						mismatches++;
					end
					if (got.sat !== want.sat) begin
						$error("saturated: expected %0b, got %0b", want.sat, got.sat);
						mismatches++;
					end
				end
			end else begin
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(negedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$error("no transaction for %0d cycles", quiet);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int i;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_WRITE;
		cfg_valid = 1'b0;
		cfg_index = REG_ROWS;
		cfg_data = '0;
		for (i = 0; i < CELLS; i++) begin
			grid_val[i] = '0;
			fixed_cell[i] = 1'b0;
		end
		rows_cfg = 16;
		cols_cfg = 16;
		row_coef = 0;
		col_coef = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_write_read();
		test_clipping();
		test_backpressure();
		test_random_phases();
		wait_idle();

		$display("covered %0d cell writes, %0d reads, %0d grid steps (%0d clipped), %0d ignored",
			n_writes, n_reads, n_steps, n_clipped, n_ignored);
		$display("over %0d register settings; %0d results checked, %0d mismatches",
			n_settings, n_checked, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: heat_diffusion_ftcs_grid_step.f
rtl/hdf_pkg.sv
rtl/hdf_ram.sv
rtl/heat_diffusion_ftcs_grid_step.sv
dv/testbench.sv
